// ----- src/ppc_pkg.sv -----
// Shared types and constants for the permutation power cipher.
`default_nettype none
package ppc_pkg;
   localparam int MAX_BLOCK = 64;
   localparam int IDX_W = $clog2(MAX_BLOCK);
   localparam int LEN_W = IDX_W + 1;
   localparam int ROUNDS_W = 31;
   localparam int CNT_W = $clog2(ROUNDS_W);
   localparam logic [7:0] PAD_CHAR = 8'h20;
   localparam logic [LEN_W-1:0] BLEN_RESET = LEN_W'(MAX_BLOCK);
   localparam logic [1:0] ADDR_BLEN = 2'd0;
   localparam logic MODE_LOAD = 1'b0;

   typedef struct packed {
      logic                mode;
      logic [IDX_W-1:0]    position;
      logic [IDX_W-1:0]    target;
      logic [7:0]          character;
      logic [ROUNDS_W-1:0] rounds;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_character;
      logic [IDX_W-1:0] out_position;
      logic             out_last;
   } rsp_type;

   // status of the modulo unit
   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;
endpackage
`default_nettype wire

// ----- src/ppc_mod.sv -----
// Bit-serial modulo unit: rounds mod cycle length, one dividend bit per cycle.
`default_nettype none
module ppc_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppc_pkg::ROUNDS_W-1:0] dividend,
   input  logic [ppc_pkg::LEN_W-1:0]    divisor,
   output ppc_pkg::mod_stat_type        stat,
   output logic [ppc_pkg::IDX_W-1:0]    remainder
);
   import ppc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ROUNDS_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]    div_ff, div_in;
   logic [LEN_W-1:0]    trial;

   // restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[ROUNDS_W-1]};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= div_ff) begin
            rem_in = IDX_W'(trial - div_ff);
         end else begin
            rem_in = trial[IDX_W-1:0];
         end
         quo_in = quo_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROUNDS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < div_ff))
      else $error("remainder not below divisor");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("modulo unit did not start");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done longer than one cycle");
endmodule
`default_nettype wire

// ----- src/permutation_power_cipher.sv -----
// Top level: tables, sequencer for cycle walks and scatter, output emission.
// Mode 0 and non-final characters are taken back to back while idle.
// A final character, per position, walks the cycle to find its length,
// takes rounds mod length, steps that far and scatters; then the block is
// emitted byte by byte, no stalls. Each walk step is one permutation table
// read. Synchronous reset clears control state and sets block_length to 64.
`default_nettype none
module permutation_power_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ppc_pkg::req_type req_data,
   output logic             rsp_valid,
   output ppc_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ppc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN_RD, ST_LEN_CHK, ST_MOD_WAIT, ST_MOVE, ST_MOVE_W,
      ST_SCATTER, ST_EMIT_RD, ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    blen_ff;
   logic [LEN_W-1:0]    rcnt_ff, rcnt_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0]    nlen_ff, nlen_in;
   logic [ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    steps_ff, steps_in;
   logic [IDX_W-1:0]    outj_ff, outj_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [MAX_BLOCK-1:0] ovalid_ff;

   logic [IDX_W-1:0] perm_mem [MAX_BLOCK];
   logic [7:0]       msg_mem  [MAX_BLOCK];
   logic [7:0]       obuf_mem [MAX_BLOCK];
   logic [IDX_W-1:0] perm_q_ff;
   logic [7:0]       msg_q_ff;
   logic [7:0]       obuf_q_ff;
   logic             ovq_ff;

   logic             accept;
   logic             cfg_wr;
   logic [LEN_W-1:0] n_eff;
   logic [IDX_W-1:0] perm_rd_addr;
   logic             perm_we, msg_we, obuf_we, ovalid_clr, mod_start;
   logic [7:0]       scatter_char;
   mod_stat_type     mod_stat;
   logic [IDX_W-1:0] mod_rem;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BLEN);

   // clamp block length into 1..MAX_BLOCK
   always_comb begin
      if (blen_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (blen_ff > LEN_W'(MAX_BLOCK)) begin
         n_eff = LEN_W'(MAX_BLOCK);
      end else begin
         n_eff = blen_ff;
      end
   end

   assign scatter_char = ({1'b0, idx_ff} < fill_ff) ? msg_q_ff : PAD_CHAR;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rcnt_in      = rcnt_ff;
      fill_in      = fill_ff;
      nlen_in      = nlen_ff;
      rounds_in    = rounds_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      outj_in      = outj_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      perm_rd_addr = idx_ff;
      perm_we      = 1'b0;
      msg_we       = 1'b0;
      obuf_we      = 1'b0;
      ovalid_clr   = 1'b0;
      mod_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_LOAD) begin
                  perm_we = 1'b1;
               end else begin
                  if (rcnt_ff < n_eff) begin
                     msg_we  = 1'b1;
                     rcnt_in = rcnt_ff + 1'b1;
                  end
                  if (req_data.last) begin
                     fill_in    = rcnt_in;
                     nlen_in    = n_eff;
                     rounds_in  = req_data.rounds;
                     idx_in     = '0;
                     ovalid_clr = 1'b1;
                     state_in   = ST_LEN_RD;
                  end
               end
            end
         end
         ST_LEN_RD: begin
            len_in   = LEN_W'(1);
            state_in = ST_LEN_CHK;
         end
         ST_LEN_CHK: begin
            // one table read per step along the cycle
            if (perm_q_ff != idx_ff && len_ff < nlen_ff) begin
               perm_rd_addr = perm_q_ff;
               len_in       = len_ff + 1'b1;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_MOD_WAIT;
            end
         end
         ST_MOD_WAIT: begin
            if (mod_stat.done) begin
               steps_in = mod_rem;
               pos_in   = idx_ff;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (steps_ff == '0) begin
               state_in = ST_SCATTER;
            end else begin
               perm_rd_addr = pos_ff;
               state_in     = ST_MOVE_W;
            end
         end
         ST_MOVE_W: begin
            pos_in   = perm_q_ff;
            steps_in = steps_ff - 1'b1;
            state_in = ST_MOVE;
         end
         ST_SCATTER: begin
            obuf_we = ({1'b0, pos_ff} < nlen_ff);
            if ({1'b0, idx_ff} + 1'b1 == nlen_ff) begin
               outj_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_LEN_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.out_character = ovq_ff ? obuf_q_ff : PAD_CHAR;
            rsp_data_in.out_position  = outj_ff;
            rsp_data_in.out_last      = ({1'b0, outj_ff} + 1'b1 == nlen_ff);
            if (rsp_data_in.out_last) begin
               rcnt_in  = '0;
               state_in = ST_IDLE;
            end else begin
               outj_in  = outj_ff + 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rcnt_ff      <= '0;
         blen_ff      <= BLEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            blen_ff <= pwdata[LEN_W-1:0];
         end
      end
      fill_ff     <= fill_in;
      nlen_ff     <= nlen_in;
      rounds_ff   <= rounds_in;
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      steps_ff    <= steps_in;
      outj_ff     <= outj_in;
      rsp_data_ff <= rsp_data_in;
   end

   // written flags of the output buffer; unwritten reads as pad
   always_ff @(posedge clock) begin
      if (reset || ovalid_clr) begin
         ovalid_ff <= '0;
      end else if (obuf_we) begin
         ovalid_ff[pos_ff] <= 1'b1;
      end
   end

   // permutation table
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[req_data.position] <= req_data.target;
      end
      perm_q_ff <= perm_mem[perm_rd_addr];
   end

   // message buffer
   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[rcnt_ff[IDX_W-1:0]] <= req_data.character;
      end
      msg_q_ff <= msg_mem[idx_ff];
   end

   // output buffer
   always_ff @(posedge clock) begin
      if (obuf_we) begin
         obuf_mem[pos_ff] <= scatter_char;
      end
      obuf_q_ff <= obuf_mem[outj_ff];
      ovq_ff    <= ovalid_ff[outj_ff];
   end

   ppc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rounds_ff),
      .divisor   (len_ff),
      .stat      (mod_stat),
      .remainder (mod_rem)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == ADDR_BLEN) ? {{(32-LEN_W){1'b0}}, blen_ff} : '0;

   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.out_last) |-> busy)
      else $error("result outside of emission");
   a_out_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back to back results");
   a_rcnt_range: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= LEN_W'(MAX_BLOCK))
      else $error("received count overflow");
   a_mod_idle_start: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> !mod_stat.busy)
      else $error("modulo started while busy");
endmodule
`default_nettype wire
